// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Sizes, operation and status codes, and the word formats of both channels.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY     = 16;
	localparam int PAYLOAD_BITS = 32;
	localparam int CNT_W        = $clog2(CAPACITY + 1);
	localparam int OCC_W        = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	// request word
	typedef struct packed {
		logic               operation;
		logic signed [31:0] key;
		logic        [31:0] payload;
	} spq_req_t;

	// response word
	typedef struct packed {
		logic        [1:0]       status;
		logic signed [31:0]      out_key;
		logic        [31:0]      out_payload;
		logic        [OCC_W-1:0] occupancy;
	} spq_rsp_t;

	// one stored entry
	typedef struct packed {
		logic signed [31:0]             key;
		logic        [PAYLOAD_BITS-1:0] payload;
	} spq_entry_t;

	// command broadcast to every cell
	typedef struct packed {
		logic       insert;
		logic       pop;
		spq_entry_t ent;
	} spq_cmd_t;

endpackage

// ===== rtl/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor; on pop it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
	input  logic       clk,
	input  spq_cmd_t   cmd,
	input  logic       occupied,
	input  logic       prev_go,
	input  spq_entry_t prev_ent,
	input  spq_entry_t next_ent,
	output logic       go,
	output spq_entry_t ent
);

	spq_entry_t ent_q;

	// new entry belongs at or left of this slot: strictly smaller key or free slot
	assign go  = cmd.insert && (!occupied || ($signed(cmd.ent.key) < $signed(ent_q.key)));
	assign ent = ent_q;

	// shift right on insert, shift left on pop
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (prev_go) begin
				ent_q <= prev_ent;
			end else if (go) begin
				ent_q <= cmd.ent;
			end
		end else if (cmd.pop) begin
			ent_q <= next_ent;
		end
	end

endmodule

// ===== rtl/sorted_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top: bounded min-first priority queue
// Chain of CAPACITY cells kept sorted by ascending key, ties in arrival order.
// ----------------------------------------------------------------------------
// One request word (insert or pop) is taken per cycle: every cell compares
// the incoming key against its own entry in parallel and the whole chain
// shifts at once, so there is no backlog. The response for a
// request appears in the output register on the next cycle; the request side
// stalls only while that register holds a word that is itself stalled. A pop
// on an empty queue returns the empty status, an insert into a full queue is
// dropped and returns the full status. No clearing pass follows reset.
module sorted_priority_queue_top import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  spq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output spq_rsp_t rsp
);

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	spq_rsp_t         rsp_q;

	logic       accept;
	logic       full;
	logic       empty;
	spq_cmd_t   cmd;
	logic       go   [CAPACITY];
	spq_entry_t ent  [CAPACITY];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);

	// build the command seen by every cell
	always_comb begin
		cmd.insert      = accept && (req.operation == OP_INSERT) && !full;
		cmd.pop         = accept && (req.operation == OP_POP) && !empty;
		cmd.ent.key     = req.key;
		cmd.ent.payload = PAYLOAD_BITS'(req.payload);
	end

	// the cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.occupied (CNT_W'(i) < count_q),
			.prev_go  ((i == 0) ? 1'b0 : go[(i == 0) ? 0 : i - 1]),
			.prev_ent ((i == 0) ? cmd.ent : ent[(i == 0) ? 0 : i - 1]),
			.next_ent ((i == CAPACITY - 1) ? ent[i] : ent[(i == CAPACITY - 1) ? i : i + 1]),
			.go       (go[i]),
			.ent      (ent[i])
		);
	end

	// track the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	// hold the response word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// form the response from the state before the update
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status      <= ST_OK;
			rsp_q.out_key     <= '0;
			rsp_q.out_payload <= '0;
			if (req.operation == OP_INSERT) begin
				rsp_q.status    <= full ? ST_FULL : ST_OK;
				rsp_q.occupancy <= full ? OCC_W'(count_q) : OCC_W'(count_q + 1'b1);
			end else if (empty) begin
				rsp_q.status    <= ST_EMPTY;
				rsp_q.occupancy <= '0;
			end else begin
				rsp_q.out_key     <= ent[0].key;
				rsp_q.out_payload <= 32'(ent[0].payload);
				rsp_q.occupancy   <= OCC_W'(count_q - 1'b1);
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// fill count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	// a pop on an empty queue reports the empty status
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.operation == OP_POP) && empty |=> rsp_q.status == ST_EMPTY)
		else $error("empty pop not flagged");

	// an insert into a full queue leaves the count alone and reports full
	a_ins_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.operation == OP_INSERT) && full |=>
		(count_q == $past(count_q)) && (rsp_q.status == ST_FULL))
		else $error("full insert not dropped");

	// an accepted insert grows the count by one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("insert did not grow the count");

endmodule

// ===== sim/spq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker: response checker for the sorted priority queue
// Watches both channels, keeps its own sorted copy of the queue contents,
// predicts the response word of every accepted request word and compares it
// field by field with the response words the block delivers, in order.
// ----------------------------------------------------------------------------
module spq_checker import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_stall,
	input  spq_req_t req,
	input  logic     rsp_valid,
	input  logic     rsp_stall,
	input  spq_rsp_t rsp,
	output int       failures,
	output int       pending_count
);

	// sorted shadow of the queue, head at index 0
	spq_entry_t shadow_entries [CAPACITY];
	int         shadow_fill;

	// response words predicted but not yet delivered
	spq_rsp_t   pending_answers [$];
	spq_rsp_t   want_word;
	int         errors;

	task automatic report_error(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		errors++;
	endtask

	// apply one request word to the shadow and return the response it earns
	function automatic spq_rsp_t predict_answer(input spq_req_t r);
		spq_rsp_t           ans;
		logic signed [31:0] new_key;
		int                 pos;
		int                 i;
		ans = '0;
		new_key = r.key;
		if (r.operation == OP_INSERT) begin
			if (shadow_fill >= CAPACITY) begin
				ans.status = ST_FULL;
			end else begin
				// land after every entry whose key is not greater
				pos = 0;
				while (pos < shadow_fill &&
				       !($signed(new_key) < $signed(shadow_entries[pos].key)))
					pos++;
				for (i = shadow_fill; i > pos; i--)
					shadow_entries[i] = shadow_entries[i-1];
				shadow_entries[pos].key = new_key;
				shadow_entries[pos].payload = r.payload[PAYLOAD_BITS-1:0];
				shadow_fill++;
			end
		end else begin
			if (shadow_fill == 0) begin
				ans.status = ST_EMPTY;
			end else begin
				// take the head and close the gap
				ans.out_key = shadow_entries[0].key;
				ans.out_payload = 32'(shadow_entries[0].payload);
				for (i = 1; i < shadow_fill; i++)
					shadow_entries[i-1] = shadow_entries[i];
				shadow_fill--;
			end
		end
		ans.occupancy = OCC_W'(shadow_fill);
		return ans;
	endfunction

	// predict on every accepted request, compare on every accepted response
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_answers.delete();
			shadow_fill = 0;
			errors = 0;
			failures <= 0;
			pending_count <= 0;
		end else begin
			if (req_valid && !req_stall)
				pending_answers.push_back(predict_answer(req));
			if (rsp_valid && !rsp_stall) begin
				if (pending_answers.size() == 0) begin
					report_error($sformatf("response word %h with none expected", rsp));
				end else begin
					want_word = pending_answers.pop_front();
					if (rsp.status !== want_word.status)
						report_error($sformatf("status got %0d want %0d",
							rsp.status, want_word.status));
					if (rsp.out_key !== want_word.out_key)
						report_error($sformatf("out_key got %h want %h",
							rsp.out_key, want_word.out_key));
					if (rsp.out_payload !== want_word.out_payload)
						report_error($sformatf("out_payload got %h want %h",
							rsp.out_payload, want_word.out_payload));
					if (rsp.occupancy !== want_word.occupancy)
						report_error($sformatf("occupancy got %0d want %0d",
							rsp.occupancy, want_word.occupancy));
				end
			end
			failures <= errors;
			pending_count <= pending_answers.size();
		end
	end

endmodule

// ===== sim/sorted_priority_queue_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_test: testbench of the sorted priority queue
// Drives a directed opening (empty pop, extreme and tied keys, a full queue,
// a dropped insert) and then random insert/pop traffic in bursts whose mix
// swings the queue between empty and full, while the response side stalls on
// its own pattern. A separate checker predicts and compares every word.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_test;
	import spq_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	spq_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	spq_rsp_t rsp;

	int       failures;
	int       pending_count;
	int       cycle_count = 0;

	// response stall pattern state
	int       stall_mode = 0;
	int       stall_left = 0;

	sorted_priority_queue_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	spq_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.failures      (failures),
		.pending_count (pending_count)
	);

	always #5 clk = ~clk;

	// abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// stall the response side: free runs, light and heavy random, a periodic pattern
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 120);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: begin
				rsp_stall <= 1'b0;
			end
			1: begin
				rsp_stall <= ($urandom_range(0, 3) == 0);
			end
			2: begin
				rsp_stall <= ($urandom_range(0, 1) == 0);
			end
			default: begin
				rsp_stall <= ((stall_left % 7) < 4);
			end
		endcase
	end

	function automatic spq_req_t req_word(input logic op, input logic [31:0] k,
	                                      input logic [31:0] pay);
		spq_req_t w;
		w.operation = op;
		w.key = k;
		w.payload = pay;
		return w;
	endfunction

	// mix of wide random keys, tie-prone small keys and the extremes
	function automatic logic [31:0] pick_key();
		logic [31:0] k;
		case ($urandom_range(0, 5))
			0, 1: k = $urandom;
			2, 3: k = 32'($signed($urandom_range(0, 8)) - 4);
			4: k = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: k = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
			                                  : 32'h7fff_ffff - $urandom_range(0, 3);
		endcase
		return k;
	endfunction

	// present one word and hold it until taken
	task automatic send_word(input spq_req_t w);
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	initial begin
		int sent;
		int burst;
		int j;
		int regime;
		int regime_left;
		int pop_pct;
		logic op;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pop on an empty queue
		send_word(req_word(OP_POP, 32'h1234_5678, 32'hdead_beef));

		// fill to capacity: extremes, ties at min, max and in the middle
		send_word(req_word(OP_INSERT, 32'h0000_0000, 32'h0000_0000));
		send_word(req_word(OP_INSERT, 32'h8000_0000, 32'hffff_ffff));
		send_word(req_word(OP_INSERT, 32'h7fff_ffff, 32'h0000_0001));
		send_word(req_word(OP_INSERT, 32'hffff_ffff, 32'h8000_0000));
		send_word(req_word(OP_INSERT, 32'h0000_0005, 32'h0000_000a));
		send_word(req_word(OP_INSERT, 32'h0000_0005, 32'h0000_000b));
		send_word(req_word(OP_INSERT, 32'h0000_0005, 32'h0000_000c));
		send_word(req_word(OP_INSERT, 32'h0000_0001, 32'h5555_5555));
		send_word(req_word(OP_INSERT, 32'h8000_0000, 32'haaaa_aaaa));
		send_word(req_word(OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff));
		send_word(req_word(OP_INSERT, 32'h0000_0003, 32'h0f0f_0f0f));
		send_word(req_word(OP_INSERT, 32'hffff_fff9, 32'hf0f0_f0f0));
		send_word(req_word(OP_INSERT, 32'h0000_0064, 32'h0000_ffff));
		send_word(req_word(OP_INSERT, 32'hffff_ff9c, 32'hffff_0000));
		send_word(req_word(OP_INSERT, 32'h0000_0000, 32'h1111_1111));
		send_word(req_word(OP_INSERT, 32'h0000_0007, 32'h2222_2222));

		// insert into a full queue is dropped
		send_word(req_word(OP_INSERT, 32'h8000_0000, 32'h5a5a_5a5a));

		// drain the head; the rest leaves during random traffic
		repeat (6) send_word(req_word(OP_POP, 32'hffff_ffff, 32'hffff_ffff));

		// random traffic in bursts; regimes push toward full or empty
		sent = 0;
		regime = 2;
		regime_left = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 20);
			for (j = 0; j < burst; j++) begin
				if (regime_left == 0) begin
					regime = $urandom_range(0, 2);
					regime_left = $urandom_range(20, 60);
				end
				regime_left--;
				pop_pct = (regime == 0) ? 20 : (regime == 1) ? 80 : 50;
				op = ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_INSERT;
				send_word(req_word(op, pick_key(), $urandom));
				sent++;
			end
			if ($urandom_range(0, 3) == 0)
				idle_cycles(0);
			else
				idle_cycles($urandom_range(1, 8));
		end
		req_valid <= 1'b0;

		// let the checker count the last word, wait out the responses, then settle
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0 && pending_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
